### sv/sae_pkg.sv
// Package for the suffix automaton extension block.
// Holds the item structs, status codes and default sizes; no dependencies.
`default_nettype none
package sae_pkg;

  localparam int MAX_STATES_DEF   = 4096;
  localparam int ALPHABET_MAX_DEF = 10;
  localparam logic [24:0] COUNT_MAX = 25'h1FF_FFFF;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [11:0] prev_state;
    logic [3:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [11:0] new_state;
    logic [24:0] distinct_count;
    logic [1:0]  status;
  } out_item_t;

endpackage
`default_nettype wire

### sv/sae_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Used for the transition, length and link tables; no dependencies.
`default_nettype none
module sae_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/suffix_automaton_extend.sv
// Top level of the suffix automaton extension block: sequencer, tables, output register.
// Depends on sae_pkg and sae_ram.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   sae_pkg::in_item_t
//   out_     output     out_valid/out_stall sae_pkg::out_item_t
//   cfg_     input      cfg_we              alphabet_size, 4 bits
//
// Items are taken one at a time; an item walks suffix links while setting and redirecting
// transitions, and each table has a single read port, so its table reads run one after another.
// After reset a clearing pass clears the root before any item is taken.
// in_stall is high while an item is at work; a stalled result waits in the output register.
`default_nettype none
module suffix_automaton_extend #(
  parameter int MAX_STATES   = sae_pkg::MAX_STATES_DEF,
  parameter int ALPHABET_MAX = sae_pkg::ALPHABET_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sae_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sae_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int LW = SW + 1;
  localparam int TD = MAX_STATES * ALPHABET_MAX;
  localparam int TW = $clog2(TD);
  localparam int JW = $clog2(ALPHABET_MAX);
  localparam logic [JW-1:0] J_LAST = JW'(ALPHABET_MAX - 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LENP, S_CLRU, S_W1, S_W2, S_W3, S_Q1, S_Q2,
    S_CL1, S_CL2, S_CL3, S_CPR, S_CPW, S_R1, S_R2, S_R3, S_ADD, S_FIN
  } state_t;

  function automatic logic [TW-1:0] slot(input logic [SW-1:0] st, input logic [JW-1:0] sym);
    slot = TW'(st) * TW'(ALPHABET_MAX) + TW'(sym);
  endfunction

  state_t         state_r;
  logic [3:0]     cfg_r;
  logic [SW-1:0]  cur_r, u_r, q_r, cl_r;
  logic [JW-1:0]  s_r, j_r;
  logic [LW-1:0]  lenu_r, lencur_r, add_r;
  logic [LW-1:0]  count_r;
  logic [24:0]    total_r;
  logic [1:0]     status_r;
  logic           out_valid_r;
  sae_pkg::out_item_t out_r;

  logic           t_we;
  logic [TW-1:0]  t_waddr, t_raddr;
  logic [SW:0]    t_wdata, t_rdata;
  logic           l_we;
  logic [SW-1:0]  l_waddr, l_raddr;
  logic [LW-1:0]  l_wdata, l_rdata;
  logic           k_we;
  logic [SW-1:0]  k_waddr, k_raddr;
  logic [SW-1:0]  k_wdata, k_rdata;

  logic           bad_in, full_tab, t_valid, out_free;
  logic [SW-1:0]  t_target;
  logic [25:0]    sum;

  assign t_valid  = t_rdata[SW];
  assign t_target = t_rdata[SW-1:0];
  assign bad_in   = (in_data.symbol >= cfg_r) || (32'(in_data.symbol) >= ALPHABET_MAX)
                    || (32'(in_data.prev_state) >= 32'(count_r));
  assign full_tab = (32'(count_r) + 32'd2) > MAX_STATES;
  assign sum      = {1'b0, total_r} + 26'(add_r);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sae_ram #(.DEPTH(TD), .WIDTH(SW + 1)) u_trans (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );
  sae_ram #(.DEPTH(MAX_STATES), .WIDTH(LW)) u_len (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );
  sae_ram #(.DEPTH(MAX_STATES), .WIDTH(SW)) u_link (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );

  always_comb begin
    t_we = 1'b0; t_waddr = slot(cur_r, s_r); t_wdata = '0; t_raddr = slot(cur_r, s_r);
    l_we = 1'b0; l_waddr = u_r; l_wdata = '0; l_raddr = cur_r;
    k_we = 1'b0; k_waddr = u_r; k_wdata = '0; k_raddr = cur_r;
    unique case (state_r)
      S_INIT: begin
        t_we = 1'b1; t_waddr = slot('0, j_r);
        l_we = 1'b1; l_waddr = '0;
        k_we = 1'b1; k_waddr = '0;
      end
      S_IDLE: l_raddr = SW'(in_data.prev_state);
      S_LENP: begin
        l_we = 1'b1; l_wdata = l_rdata + LW'(1);
      end
      S_CLRU: begin
        t_we = 1'b1; t_waddr = slot(u_r, j_r);
      end
      S_W2: begin
        if (!t_valid) begin
          t_we = 1'b1; t_wdata = {1'b1, u_r};
          k_we = (cur_r == '0);
        end
      end
      S_Q1: l_raddr = q_r;
      S_Q2: k_raddr = q_r;
      S_CL1: begin
        k_we = 1'b1; k_waddr = cl_r; k_wdata = k_rdata;
      end
      S_CL2: begin
        k_we = 1'b1; k_waddr = q_r; k_wdata = cl_r;
      end
      S_CL3: begin
        k_we = 1'b1; k_wdata = cl_r;
        l_we = 1'b1; l_waddr = cl_r; l_wdata = lencur_r + LW'(1);
      end
      S_CPR: t_raddr = slot(q_r, j_r);
      S_CPW: begin
        t_we = 1'b1; t_waddr = slot(cl_r, j_r); t_wdata = t_rdata;
      end
      S_R2: begin
        if (t_valid && t_target == q_r) begin
          t_we = 1'b1; t_wdata = {1'b1, cl_r};
        end
      end
      default: ;
    endcase
    if (state_r == S_Q2 && lencur_r + LW'(1) == l_rdata) begin
      k_we = 1'b1; k_wdata = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      j_r         <= '0;
      cfg_r       <= 4'd10;
      count_r     <= LW'(1);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          j_r <= j_r + JW'(1);
          if (j_r == J_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_r <= SW'(in_data.prev_state);
            s_r   <= JW'(in_data.symbol);
            u_r   <= count_r[SW-1:0];
            j_r   <= '0;
            if (bad_in) begin
              status_r <= sae_pkg::ST_BAD;
              state_r  <= S_FIN;
            end else if (full_tab) begin
              status_r <= sae_pkg::ST_FULL;
              state_r  <= S_FIN;
            end else begin
              status_r <= sae_pkg::ST_OK;
              count_r  <= count_r + LW'(1);
              state_r  <= S_LENP;
            end
          end
        end
        S_LENP: begin
          lenu_r  <= l_rdata + LW'(1);
          state_r <= S_CLRU;
        end
        S_CLRU: begin
          j_r <= j_r + JW'(1);
          if (j_r == J_LAST) begin
            state_r <= S_W1;
          end
        end
        S_W1: state_r <= S_W2;
        S_W2: begin
          if (t_valid) begin
            q_r     <= t_target;
            state_r <= S_Q1;
          end else if (cur_r == '0) begin
            add_r   <= lenu_r;
            state_r <= S_ADD;
          end else begin
            state_r <= S_W3;
          end
        end
        S_W3: begin
          cur_r   <= k_rdata;
          state_r <= S_W1;
        end
        S_Q1: begin
          lencur_r <= l_rdata;
          state_r  <= S_Q2;
        end
        S_Q2: begin
          if (lencur_r + LW'(1) == l_rdata) begin
            add_r   <= lenu_r - l_rdata;
            state_r <= S_ADD;
          end else begin
            cl_r    <= count_r[SW-1:0];
            count_r <= count_r + LW'(1);
            state_r <= S_CL1;
          end
        end
        S_CL1: state_r <= S_CL2;
        S_CL2: state_r <= S_CL3;
        S_CL3: begin
          j_r     <= '0;
          state_r <= S_CPR;
        end
        S_CPR: state_r <= S_CPW;
        S_CPW: begin
          j_r <= j_r + JW'(1);
          state_r <= (j_r == J_LAST) ? S_R1 : S_CPR;
        end
        S_R1: state_r <= S_R2;
        S_R2: begin
          if (!t_valid || t_target != q_r || cur_r == '0) begin
            add_r   <= lenu_r - (lencur_r + LW'(1));
            state_r <= S_ADD;
          end else begin
            state_r <= S_R3;
          end
        end
        S_R3: begin
          cur_r   <= k_rdata;
          state_r <= S_R1;
        end
        S_ADD: begin
          total_r <= (sum > {1'b0, sae_pkg::COUNT_MAX}) ? sae_pkg::COUNT_MAX : sum[24:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_r.new_state      <= (status_r == sae_pkg::ST_OK) ? 12'(u_r) : 12'd0;
            out_r.distinct_count <= total_r;
            out_r.status         <= status_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/sae_check.sv
// Port-level checker for the suffix automaton extension block and its bind.
// Depends on sae_pkg and suffix_automaton_extend.
`default_nettype none
module sae_check (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sae_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item at work");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != sae_pkg::ST_OK |-> out_data.new_state == 12'd0)
    else $error("rejected item reports a state");

  a_ok_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sae_pkg::ST_OK |-> out_data.new_state != 12'd0)
    else $error("new state is the root");

endmodule

bind suffix_automaton_extend sae_check u_sae_check (.*);
`default_nettype wire

### tb/sv/suffix_automaton_extend_tb.sv
// Testbench for suffix_automaton_extend: drives extension items, predicts each result
// with a local suffix automaton and checks every result item. Depends on sae_pkg and suffix_automaton_extend.
`default_nettype none
module suffix_automaton_extend_tb;

  localparam int NSTATES = sae_pkg::MAX_STATES_DEF;
  localparam int NSYM = sae_pkg::ALPHABET_MAX_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  sae_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  sae_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [3:0] cfg_wdata = '0;

  suffix_automaton_extend dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [11:0] edge_target [NSTATES*NSYM];
  bit edge_valid [NSTATES*NSYM];
  int unsigned state_len [NSTATES];
  int unsigned state_link [NSTATES];
  int unsigned num_states;
  int unsigned substr_total;
  logic [3:0] alpha_reg;
  int unsigned last_new;

  sae_pkg::out_item_t pending_results[$];
  int fails = 0;
  int cycles = 0;
  bit quiet = 0;
  int stall_left = 0;
  bit took = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  function automatic sae_pkg::out_item_t extend_automaton(input logic [11:0] p,
                                                          input logic [3:0] s);
    sae_pkg::out_item_t r;
    int unsigned asz, u, cur, q, cl, add;
    bit at_end;
    asz = (alpha_reg > NSYM) ? NSYM : alpha_reg;
    r.new_state = '0;
    r.distinct_count = substr_total[24:0];
    at_end = 0;
    if (s >= asz || p >= num_states) begin
      r.status = sae_pkg::ST_BAD;
      return r;
    end
    if (NSTATES - num_states < 2) begin
      r.status = sae_pkg::ST_FULL;
      return r;
    end
    u = num_states++;
    state_len[u] = state_len[p] + 1;
    for (int k = 0; k < NSYM; k++) edge_valid[u*NSYM+k] = 0;
    cur = p;
    forever begin
      if (edge_valid[cur*NSYM+s]) break;
      edge_valid[cur*NSYM+s] = 1;
      edge_target[cur*NSYM+s] = u[11:0];
      if (cur == 0) begin
        at_end = 1;
        break;
      end
      cur = state_link[cur];
    end
    if (at_end) begin
      state_link[u] = 0;
    end else begin
      q = edge_target[cur*NSYM+s];
      if (state_len[cur] + 1 == state_len[q]) begin
        state_link[u] = q;
      end else begin
        cl = num_states++;
        for (int k = 0; k < NSYM; k++) begin
          edge_target[cl*NSYM+k] = edge_target[q*NSYM+k];
          edge_valid[cl*NSYM+k] = edge_valid[q*NSYM+k];
        end
        state_len[cl] = state_len[cur] + 1;
        state_link[cl] = state_link[q];
        state_link[q] = cl;
        state_link[u] = cl;
        forever begin
          if (!edge_valid[cur*NSYM+s] || edge_target[cur*NSYM+s] != q) break;
          edge_target[cur*NSYM+s] = cl[11:0];
          if (cur == 0) break;
          cur = state_link[cur];
        end
      end
    end
    add = state_len[u] - state_len[state_link[u]];
    if (add > sae_pkg::COUNT_MAX - substr_total) substr_total = sae_pkg::COUNT_MAX;
    else substr_total += add;
    r.new_state = u[11:0];
    r.distinct_count = substr_total[24:0];
    r.status = sae_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_item(input logic [11:0] p, input logic [3:0] s);
    int gap;
    sae_pkg::out_item_t r;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{prev_state: p, symbol: s};
    r = extend_automaton(p, s);
    if (r.status == sae_pkg::ST_OK) last_new = r.new_state;
    pending_results = {pending_results, r};
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic write_alphabet(input logic [3:0] v);
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    alpha_reg = v;
  endtask

  always @(negedge clk) begin
    sae_pkg::out_item_t e;
    took = 0;
    if (rst_n && out_valid && !out_stall) begin
      took = 1;
      if (pending_results.size() == 0) begin
        report("unexpected result, new_state", out_data.new_state, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) report("status", out_data.status, e.status);
        if (out_data.new_state !== e.new_state)
          report("new_state", out_data.new_state, e.new_state);
        if (out_data.distinct_count !== e.distinct_count)
          report("distinct_count", out_data.distinct_count, e.distinct_count);
      end
    end
  end

  always @(posedge clk) begin
    if (took) stall_left = quiet ? 0 : $urandom_range(0, 5);
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left--;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(12'd0, 4'd0);
    send_item(12'd1, 4'd0);
    send_item(12'd2, 4'd1);
    send_item(12'd0, 4'd9);
    send_item(12'd0, 4'd0);
    send_item(12'd0, 4'd15);
    send_item(12'd0, 4'd10);
    send_item(12'd4095, 4'd0);
    send_item(num_states[11:0], 4'd0);
    send_item(12'd3, 4'd0);
    send_item(12'd1, 4'd1);
    send_item(last_new[11:0], 4'd9);
    send_item(12'd2, 4'd0);
  endtask

  task automatic test_alphabet_extremes();
    write_alphabet(4'd1);
    send_item(12'd0, 4'd0);
    send_item(last_new[11:0], 4'd0);
    send_item(12'd0, 4'd1);
    write_alphabet(4'd0);
    send_item(12'd0, 4'd0);
    write_alphabet(4'd15);
    send_item(12'd0, 4'd9);
    send_item(12'd0, 4'd10);
    write_alphabet(4'd10);
    send_item(last_new[11:0], 4'd5);
  endtask

  task automatic test_random();
    int unsigned a, pick, p, s;
    for (int ph = 0; ph < 6; ph++) begin
      a = (ph == 0) ? 2 : $urandom_range(1, 15);
      write_alphabet(a[3:0]);
      quiet = (ph % 3 == 2);
      for (int i = 0; i < 105; i++) begin
        pick = $urandom_range(0, 99);
        if (a > NSYM) a = NSYM;
        if (pick < 70) begin
          p = ($urandom_range(0, 9) == 0) ? 0 : last_new;
          s = $urandom_range(0, a - 1);
        end else if (pick < 85) begin
          p = $urandom_range(0, num_states - 1);
          s = $urandom_range(0, a - 1);
        end else begin
          p = $urandom_range(0, 4095);
          s = $urandom_range(0, 15);
        end
        send_item(p[11:0], s[3:0]);
      end
    end
    quiet = 0;
  endtask

  initial begin
    for (int k = 0; k < NSYM; k++) edge_valid[k] = 0;
    state_len[0] = 0;
    state_link[0] = 0;
    num_states = 1;
    substr_total = 0;
    alpha_reg = 4'd10;
    last_new = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_alphabet_extremes();
    test_random();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/sae_pkg.sv
sv/sae_ram.sv
sv/suffix_automaton_extend.sv
sv/sae_check.sv
tb/sv/suffix_automaton_extend_tb.sv
